// ===== rtl/core/lpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the linear parameter ramp.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAME_BITS = 24;   // width of the frame counter
  localparam int LEVEL_BITS = 32;   // Q16.16 level width
  localparam int DIV_BITS   = LEVEL_BITS + 1;  // exact difference width
  localparam int CNT_W      = $clog2(DIV_BITS + 1);

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_VALUE  = 2'd1,
    CMD_SET_TARGET = 2'd2,
    CMD_SET_FRAMES = 2'd3
  } lpr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT,
    ST_DONE
  } lpr_state_t;

  // request to the serial divider
  typedef struct packed {
    logic                         start;
    logic signed [DIV_BITS-1:0]   dividend;
    logic [FRAME_BITS-1:0]        divisor;
  } lpr_div_req_t;

  // response from the serial divider
  typedef struct packed {
    logic                         done;
    logic signed [LEVEL_BITS-1:0] quotient;
  } lpr_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_div
// Serial signed divider: 33-bit dividend by unsigned frame count, one
// quotient bit per cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module lpr_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lpr_pkg::lpr_div_req_t req,
  output lpr_pkg::lpr_div_rsp_t      rsp
);
  import lpr_pkg::*;

  localparam logic [DIV_BITS-1:0] POS_LIM = {{(DIV_BITS-LEVEL_BITS+1){1'b0}},
                                             {(LEVEL_BITS-1){1'b1}}};

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_BITS-1:0]   quo_r, quo_nxt;
  logic [FRAME_BITS:0]   rem_r, rem_nxt;
  logic [FRAME_BITS-1:0] dsr_r, dsr_nxt;

  logic [FRAME_BITS:0]   rem_sh;
  logic                  ge;
  logic [DIV_BITS-1:0]   mag_in;
  logic [LEVEL_BITS-1:0] quo_neg;

  assign mag_in = req.dividend[DIV_BITS-1] ? DIV_BITS'(-req.dividend)
                                           : DIV_BITS'(req.dividend);

  // restoring step: bring down the next dividend bit
  assign rem_sh = {rem_r[FRAME_BITS-1:0], quo_r[DIV_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_BITS);
      neg_nxt  = req.dividend[DIV_BITS-1];
      quo_nxt  = mag_in;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      quo_nxt = {quo_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  // sign and saturation on the finished magnitude
  assign quo_neg = LEVEL_BITS'(-quo_r);

  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      if (quo_r > POS_LIM + 1'b1)
        rsp.quotient = {1'b1, {(LEVEL_BITS-1){1'b0}}};
      else
        rsp.quotient = quo_neg;
    end else begin
      if (quo_r > POS_LIM)
        rsp.quotient = {1'b0, {(LEVEL_BITS-1){1'b1}}};
      else
        rsp.quotient = quo_r[LEVEL_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/linear_parameter_ramp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_parameter_ramp
// Audio parameter ramp in signed Q16.16 with a serial step divider.
// ----------------------------------------------------------------------------
// A tick adds the per-frame step to the level (saturating) while frames
// remain, otherwise snaps the level to the target; the level waits in
// ST_DONE, then moves to the output register. Set value, set target and
// set frames recompute the step as (target - value) / frames through one
// shared restoring divider that resolves one quotient bit per cycle, so a
// set command with a non-zero frame count passes ST_CALC (start) and
// ST_WAIT (33 divider steps, then sign/saturation) before ST_DONE; with a
// zero count the step is cleared at once and it goes straight to ST_DONE.
// One item is in flight at a time; the output register lets the next item
// be taken while a result still waits on out_ready.
module linear_parameter_ramp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_command,
  input  wire logic signed [31:0]    in_level,
  input  wire logic [23:0]           in_frame_count,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_current_level
);
  import lpr_pkg::*;

  lpr_state_t state_r, state_nxt;

  logic signed [LEVEL_BITS-1:0] present_r, present_nxt;
  logic signed [LEVEL_BITS-1:0] goal_r, goal_nxt;
  logic signed [LEVEL_BITS-1:0] step_r, step_nxt;
  logic [FRAME_BITS-1:0]        frames_r, frames_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [LEVEL_BITS-1:0] out_level_r, out_level_nxt;

  lpr_div_req_t div_req;
  lpr_div_rsp_t div_rsp;

  logic [FRAME_BITS+23:0]   frame_ext;
  logic [FRAME_BITS-1:0]    frame_in;
  logic [LEVEL_BITS:0]      sum;
  logic signed [LEVEL_BITS-1:0] sum_sat;
  logic                     in_xfer;

  assign frame_ext = {{FRAME_BITS{1'b0}}, in_frame_count};
  assign frame_in  = frame_ext[FRAME_BITS-1:0];

  // saturating ramp add
  assign sum = {present_r[LEVEL_BITS-1], present_r} + {step_r[LEVEL_BITS-1], step_r};
  always_comb begin
    if (sum[LEVEL_BITS] != sum[LEVEL_BITS-1])
      sum_sat = sum[LEVEL_BITS] ? {1'b1, {(LEVEL_BITS-1){1'b0}}}
                                : {1'b0, {(LEVEL_BITS-1){1'b1}}};
    else
      sum_sat = sum[LEVEL_BITS-1:0];
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign div_req.start    = (state_r == ST_CALC);
  assign div_req.dividend = {goal_r[LEVEL_BITS-1], goal_r}
                          - {present_r[LEVEL_BITS-1], present_r};
  assign div_req.divisor  = frames_r;

  lpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    goal_nxt      = goal_r;
    step_nxt      = step_r;
    frames_nxt    = frames_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;

    if (out_valid_r && out_ready)
      out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (lpr_cmd_t'(in_command))
            CMD_TICK: begin
              if (frames_r == '0) begin
                present_nxt = goal_r;
              end else begin
                present_nxt = sum_sat;
                frames_nxt  = frames_r - 1'b1;
              end
              state_nxt = ST_DONE;
            end
            CMD_SET_VALUE: begin
              present_nxt = in_level;
              state_nxt   = (frames_r == '0) ? ST_DONE : ST_CALC;
            end
            CMD_SET_TARGET: begin
              goal_nxt  = in_level;
              state_nxt = (frames_r == '0) ? ST_DONE : ST_CALC;
            end
            CMD_SET_FRAMES: begin
              frames_nxt = frame_in;
              state_nxt  = (frame_in == '0) ? ST_DONE : ST_CALC;
            end
            default: state_nxt = ST_DONE;
          endcase
          // a zero frame count means a zero step
          if (lpr_cmd_t'(in_command) != CMD_TICK && state_nxt == ST_DONE)
            step_nxt = '0;
        end
      end
      ST_CALC: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          step_nxt  = div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = present_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      goal_r      <= '0;
      step_r      <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      goal_r      <= goal_nxt;
      step_r      <= step_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_level_r <= out_level_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_current_level = out_level_r;

endmodule
`default_nettype wire

// ===== tb/sv/lpr_ramp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpr_ramp_checker
// Watches both channels of the parameter ramp, keeps its own Q16.16 ramp
// state, and compares every returned level with the one it predicts.
// ----------------------------------------------------------------------------
module lpr_ramp_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_level,
  input  wire logic [23:0]        in_frame_count,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] out_current_level,
  output int                      mismatches,
  output int                      outstanding,
  output int                      checked
);
  import lpr_pkg::*;

  localparam longint LEVEL_HI = 64'sd2147483647;
  localparam longint LEVEL_LO = -64'sd2147483648;

  logic signed [31:0]    model_level;
  logic signed [31:0]    model_goal;
  logic signed [31:0]    model_step;
  logic [FRAME_BITS-1:0] model_frames;
  logic signed [31:0]    expected_levels[$];

  function automatic logic signed [31:0] clamp_level(input longint v);
    if (v > LEVEL_HI) return LEVEL_HI[31:0];
    if (v < LEVEL_LO) return LEVEL_LO[31:0];
    return v[31:0];
  endfunction

  // difference is exact at 64 bits; longint division truncates toward zero
  function automatic logic signed [31:0] ramp_step(input logic signed [31:0] goal,
                                                   input logic signed [31:0] value,
                                                   input logic [FRAME_BITS-1:0] frames);
    longint span;
    if (frames == '0) return '0;
    span = longint'(goal) - longint'(value);
    return clamp_level(span / longint'(frames));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic apply_command(input lpr_cmd_t cmd, input logic signed [31:0] lvl,
                               input logic [23:0] frames);
    case (cmd)
      CMD_TICK: begin
        if (model_frames == '0) begin
          model_level = model_goal;
        end else begin
          model_level  = clamp_level(longint'(model_level) + longint'(model_step));
          model_frames = model_frames - 1'b1;
        end
      end
      CMD_SET_VALUE: begin
        model_level = lvl;
        model_step  = ramp_step(model_goal, model_level, model_frames);
      end
      CMD_SET_TARGET: begin
        model_goal = lvl;
        model_step = ramp_step(model_goal, model_level, model_frames);
      end
      default: begin
        model_frames = FRAME_BITS'(frames);
        model_step   = ramp_step(model_goal, model_level, model_frames);
      end
    endcase
    expected_levels.insert(expected_levels.size(), model_level);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      model_level  = '0;
      model_goal   = '0;
      model_step   = '0;
      model_frames = '0;
      expected_levels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("level with no transfer pending", out_current_level, 'x);
        end else begin
          checked++;
          if (out_current_level !== expected_levels[0])
            report_mismatch("current_level", out_current_level, expected_levels[0]);
          void'(expected_levels.pop_front());
        end
      end
      if (in_valid && in_ready)
        apply_command(lpr_cmd_t'(in_command), in_level, in_frame_count);
    end
    outstanding = expected_levels.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the parameter ramp with directed corner cases and random ramps
// under varying back-pressure; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
  import lpr_pkg::*;

  localparam logic signed [31:0] LVL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] LVL_MIN = 32'sh8000_0000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_command;
  logic signed [31:0] in_level;
  logic [23:0]        in_frame_count;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_current_level;

  int mismatches;
  int outstanding;
  int checked;
  int snd_idle_pct;
  int rcv_idle_pct;
  int n_sent;
  int n_ticks;

  linear_parameter_ramp u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_level          (in_level),
    .in_frame_count    (in_frame_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_level (out_current_level)
  );

  lpr_ramp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_level          (in_level),
    .in_frame_count    (in_frame_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_level (out_current_level),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .checked           (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin
    #20ms;
    $display("Timeout: ramp stopped answering");
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] pick_level();
    case ($urandom_range(5))
      0:       return LVL_MAX;
      1:       return LVL_MIN;
      2:       return 32'((int'($urandom_range(4000)) - 2000) <<< 8);
      3:       return 32'(int'($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_frames();
    case ($urandom_range(19))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom_range(300, 17));
      3:       return 24'($urandom);
      default: return 24'($urandom_range(16, 1));
    endcase
  endfunction

  // returns at the falling edge after the transfer, leaving in_valid high
  task automatic send_item(input lpr_cmd_t cmd, input logic [31:0] lvl,
                           input logic [23:0] frames);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid       <= 1'b0;
      in_command     <= 2'($urandom);
      in_level       <= $urandom;
      in_frame_count <= 24'($urandom);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_level       <= lvl;
    in_frame_count <= frames;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
    if (cmd == CMD_TICK) n_ticks++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic random_traffic(input int quota);
    int             sent;
    int             span;
    int             ticks;
    logic [23:0]    frames;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) < 7) begin
        // full ramp with random content; short ones tick through to the snap
        frames = pick_frames();
        span   = (frames > 300) ? 300 : int'(frames);
        send_item(CMD_SET_VALUE, pick_level(), 24'($urandom));
        send_item(CMD_SET_TARGET, pick_level(), 24'($urandom));
        send_item(CMD_SET_FRAMES, $urandom, frames);
        ticks = (span <= 16) ? span + $urandom_range(2) : $urandom_range(40);
        repeat (ticks) send_item(CMD_TICK, $urandom, 24'($urandom));
        sent += 3 + ticks;
      end else begin
        send_item(lpr_cmd_t'($urandom_range(3)), pick_level(), pick_frames());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_TICK;
    in_level       = '0;
    in_frame_count = '0;
    snd_idle_pct   = 29;
    rcv_idle_pct   = 83;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // snap from reset, then step saturation both ways with a single frame
    send_item(CMD_TICK, LVL_MAX, 24'hFF_FFFF);
    send_item(CMD_SET_VALUE, LVL_MAX, 24'hFF_FFFF);
    send_item(CMD_SET_TARGET, LVL_MIN, 24'hFF_FFFF);
    send_item(CMD_SET_FRAMES, LVL_MAX, 24'd1);
    send_item(CMD_TICK, LVL_MIN, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SET_VALUE, LVL_MIN, '0);
    send_item(CMD_SET_TARGET, LVL_MAX, '0);
    send_item(CMD_SET_FRAMES, LVL_MIN, 24'd1);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    // truncated step leaves a residual that the extra tick removes
    send_item(CMD_SET_VALUE, '0, '0);
    send_item(CMD_SET_TARGET, 32'sd10, '0);
    send_item(CMD_SET_FRAMES, '0, 24'd3);
    repeat (4) send_item(CMD_TICK, '0, '0);
    // negative ramp truncates toward zero
    send_item(CMD_SET_TARGET, -32'sd10, '0);
    send_item(CMD_SET_FRAMES, '0, 24'd3);
    send_item(CMD_TICK, '0, '0);
    // longest ramp, then cleared count snaps
    send_item(CMD_SET_FRAMES, LVL_MAX, 24'hFF_FFFF);
    send_item(CMD_TICK, LVL_MIN, 24'hFF_FFFF);
    send_item(CMD_SET_FRAMES, '0, '0);
    send_item(CMD_TICK, LVL_MAX, 24'hFF_FFFF);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 29; rcv_idle_pct = 83; end
        1:       begin snd_idle_pct = 83; rcv_idle_pct = 29; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      random_traffic(400);
      // sender holds off until every level is back
      hold_until_drained();
    end

    repeat (40) @(negedge clk);
    $display("Covered %0d transfers (%0d ticks, %0d set commands), %0d levels checked,",
             n_sent, n_ticks, n_sent - n_ticks, checked);
    $display("with saturated steps, residual snaps and three back-pressure mixes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
